// ===== design/sqv_pkg.sv =====
// Package for the sprite quad vertex setup block.
// Transfer structs, configuration register codes and shared constants.
// No dependencies.
`default_nettype none
package sqv_pkg;

    localparam int unsigned SUM_W     = 28;
    localparam int unsigned SCREEN_LSB = 12;
    localparam logic [14:0] COLOR_WHITE = 15'h7FFF;
    localparam logic [4:0]  ALPHA_MAX   = 5'd31;
    localparam logic [1:0]  CORNER_LAST = 2'd3;

    typedef enum logic [2:0] {
        CFG_INST_ALPHA = 3'd0,
        CFG_INST_COLOR = 3'd1,
        CFG_INST_PID   = 3'd2,
        CFG_OFFSET_X   = 3'd3,
        CFG_OFFSET_Y   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [39:0]        src_rect;
        logic [1:0]         flip_flags;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [63:0]        matrix;
        logic [1:0]         priority_req;
        logic [4:0]         part_alpha;
        logic [14:0]        part_color;
        logic [5:0]         poly_id_offset;
        logic [5:0]         part_index;
    } t_part;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic [1:0]         vertex_z;
        logic [14:0]        tex_u;
        logic [14:0]        tex_v;
        logic [4:0]         vtx_alpha;
        logic [5:0]         poly_id;
        logic [14:0]        vertex_color;
        logic               last;
    } t_vtx;

    typedef struct packed {
        logic [4:0]         inst_alpha;
        logic [14:0]        inst_color;
        logic [5:0]         inst_pid;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
    } t_cfg;

    // Per-part attributes shared by all four corners.
    typedef struct packed {
        logic [14:0] u0;
        logic [14:0] u1;
        logic [14:0] v0;
        logic [14:0] v1;
        logic [1:0]  z;
        logic [4:0]  alpha;
        logic [5:0]  pid;
        logic [14:0] color;
    } t_attr;

    typedef struct packed {
        logic [SUM_W-1:0] bx;
        logic [SUM_W-1:0] by;
        logic [SUM_W-1:0] dxu;
        logic [SUM_W-1:0] dxv;
        logic [SUM_W-1:0] dyu;
        logic [SUM_W-1:0] dyv;
        t_attr            attr;
    } t_s1;

    typedef struct packed {
        logic [3:0][15:0] cx;
        logic [3:0][15:0] cy;
        t_attr            attr;
    } t_s2;

endpackage
`default_nettype wire

// ===== design/sqv_mul.sv =====
// Stage 1: matrix products, base position, texture ends, alpha, tint, id.
// Depends on sqv_pkg.
`default_nettype none
module sqv_mul import sqv_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_part i_part,
    input  wire t_cfg  i_cfg,
    output logic      o_valid,
    output t_s1       o_s1
);

    logic r_valid;
    t_s1  r_s1;
    t_s1  n_s1;

    logic [9:0]         sx, sy, w, h;
    logic signed [26:0] p0, p1, p2, p3;
    logic [14:0]        ua, ub, va, vb;
    logic [10:0]        ap;
    logic [5:0]         a6;
    logic [9:0]         cp [3];
    logic [14:0]        tinted;

    always_comb begin
        sx = i_part.src_rect[9:0];
        sy = i_part.src_rect[19:10];
        w  = i_part.src_rect[29:20];
        h  = i_part.src_rect[39:30];

        p0 = 27'($signed(i_part.matrix[15:0]))  * 27'($signed({1'b0, w}));
        p1 = 27'($signed(i_part.matrix[31:16])) * 27'($signed({1'b0, h}));
        p2 = 27'($signed(i_part.matrix[47:32])) * 27'($signed({1'b0, w}));
        p3 = 27'($signed(i_part.matrix[63:48])) * 27'($signed({1'b0, h}));

        n_s1.bx  = i_part.pos_x[SUM_W-1:0] + {i_cfg.offset_x, 12'b0};
        n_s1.by  = i_part.pos_y[SUM_W-1:0] + {i_cfg.offset_y, 12'b0};
        n_s1.dxu = {p0[26], p0};
        n_s1.dxv = {p1[26], p1};
        n_s1.dyu = {p2[26], p2};
        n_s1.dyv = {p3[26], p3};

        ua = {1'b0, sx, 4'b0};
        ub = {11'({1'b0, sx} + {1'b0, w}), 4'b0};
        va = {1'b0, sy, 4'b0};
        vb = {11'({1'b0, sy} + {1'b0, h}), 4'b0};
        n_s1.attr.u0 = i_part.flip_flags[0] ? ub : ua;
        n_s1.attr.u1 = i_part.flip_flags[0] ? ua : ub;
        n_s1.attr.v0 = i_part.flip_flags[1] ? vb : va;
        n_s1.attr.v1 = i_part.flip_flags[1] ? va : vb;

        n_s1.attr.z = i_part.priority_req;

        ap = 11'(i_part.part_alpha) * (11'(i_cfg.inst_alpha) + 11'd1);
        a6 = ap[10:5];
        n_s1.attr.alpha = (a6 > 6'(ALPHA_MAX)) ? ALPHA_MAX : a6[4:0];

        n_s1.attr.pid = 6'(i_cfg.inst_pid + i_part.poly_id_offset + i_part.part_index);

        for (int ch = 0; ch < 3; ch++) begin
            cp[ch] = 10'(i_part.part_color[5*ch +: 5]) * 10'(i_cfg.inst_color[5*ch +: 5]);
            tinted[5*ch +: 5] = cp[ch][9:5];
        end
        if (i_cfg.inst_color == COLOR_WHITE) begin
            n_s1.attr.color = i_part.part_color;
        end else if (i_part.part_color == COLOR_WHITE) begin
            n_s1.attr.color = i_cfg.inst_color;
        end else begin
            n_s1.attr.color = tinted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_s1 <= n_s1;
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule
`default_nettype wire

// ===== design/sqv_sum.sv =====
// Stage 2: corner sums, floor shift and 16-bit wrap of screen coordinates.
// Depends on sqv_pkg.
`default_nettype none
module sqv_sum import sqv_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_s1  i_s1,
    output logic      o_valid,
    output t_s2       o_s2
);

    logic             r_valid;
    t_s2              r_s2;
    t_s2              n_s2;
    logic [SUM_W-1:0] sx1, sx2, sx3, sy1, sy2, sy3;

    // Only the low SUM_W bits feed the kept field, so modular sums are exact.
    always_comb begin
        sx1 = i_s1.bx + i_s1.dxu;
        sx2 = i_s1.bx + i_s1.dxu + i_s1.dxv;
        sx3 = i_s1.bx + i_s1.dxv;
        sy1 = i_s1.by + i_s1.dyu;
        sy2 = i_s1.by + i_s1.dyu + i_s1.dyv;
        sy3 = i_s1.by + i_s1.dyv;
        n_s2.cx[0] = i_s1.bx[SUM_W-1:SCREEN_LSB];
        n_s2.cx[1] = sx1[SUM_W-1:SCREEN_LSB];
        n_s2.cx[2] = sx2[SUM_W-1:SCREEN_LSB];
        n_s2.cx[3] = sx3[SUM_W-1:SCREEN_LSB];
        n_s2.cy[0] = i_s1.by[SUM_W-1:SCREEN_LSB];
        n_s2.cy[1] = sy1[SUM_W-1:SCREEN_LSB];
        n_s2.cy[2] = sy2[SUM_W-1:SCREEN_LSB];
        n_s2.cy[3] = sy3[SUM_W-1:SCREEN_LSB];
        n_s2.attr  = i_s1.attr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_s2 <= n_s2;
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule
`default_nettype wire

// ===== design/sqv_emit.sv =====
// Stage 3: holds one quad and sends its four corners, one per cycle.
// Depends on sqv_pkg.
`default_nettype none
module sqv_emit import sqv_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_s2  i_s2,
    output logic      o_vtx_valid,
    output t_vtx      o_vtx
);

    logic       r_out_valid;
    t_vtx       r_out;
    t_s2        r_buf;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       n_out_valid;
    t_vtx       n_out;

    function automatic t_vtx corner_of(t_s2 s, logic [1:0] k);
        t_vtx v;
        v.corner       = k;
        v.vertex_x     = s.cx[k];
        v.vertex_y     = s.cy[k];
        v.vertex_z     = s.attr.z;
        v.tex_u        = (k[0] ^ k[1]) ? s.attr.u1 : s.attr.u0;
        v.tex_v        = k[1] ? s.attr.v1 : s.attr.v0;
        v.vtx_alpha    = s.attr.alpha;
        v.poly_id      = s.attr.pid;
        v.vertex_color = s.attr.color;
        v.last         = (k == CORNER_LAST);
        return v;
    endfunction

    always_comb begin
        priority if (i_valid) begin
            n_out       = corner_of(i_s2, 2'd0);
            n_out_valid = 1'b1;
            n_cnt       = 2'd1;
        end else if (r_cnt != 2'd0) begin
            n_out       = corner_of(r_buf, r_cnt);
            n_out_valid = 1'b1;
            n_cnt       = r_cnt + 2'd1;
        end else begin
            n_out       = corner_of(r_buf, r_cnt);
            n_out_valid = 1'b0;
            n_cnt       = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= 2'd0;
        end else begin
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
        r_out <= n_out;
        if (i_valid) begin
            r_buf <= i_s2;
        end
    end

    assign o_vtx_valid = r_out_valid;
    assign o_vtx       = r_out;

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> r_cnt == 2'd0)
        else $error("new quad arrived while corners still pending");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx_valid && o_vtx.corner != CORNER_LAST) |=>
        (o_vtx_valid && o_vtx.corner == 2'($past(o_vtx.corner) + 2'd1)))
        else $error("corner burst broken");

    a_pending_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0) |-> (o_vtx_valid && o_vtx.corner == 2'(r_cnt - 2'd1)))
        else $error("pending corner count out of step with output");
`endif

endmodule
`default_nettype wire

// ===== design/sprite_quad_vertex_setup.sv =====
// Top level of the sprite quad vertex setup: config registers, issue gate, stages.
// Depends on sqv_pkg, sqv_mul, sqv_sum, sqv_emit.
//
//  channel  direction  transfer when             payload
//  part     in         start && !busy            i_part  (t_part)
//  vertex   out        o_vtx_valid (no stall)    o_vtx   (t_vtx)
//  config   in         i_cfg_valid && ready      i_cfg_index, i_cfg_data
//
// A new part is not taken while busy is high, as the four corners share the result port.
// Corner 0 appears after the stage 1, stage 2 and output registers; corners 1..3 follow back to back.
// busy is high after each part transfer while r_hold counts down; o_cfg_ready is always high.
// Synchronous reset clears valids and counters and loads config reset values.
`default_nettype none
module sprite_quad_vertex_setup import sqv_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_part       i_part,
    output logic             o_vtx_valid,
    output t_vtx             o_vtx,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [1:0] r_hold;
    logic [1:0] n_hold;
    logic       accept;
    logic       s1_valid, s2_valid;
    t_s1        s1;
    t_s2        s2;

    assign accept      = start && !busy;
    assign busy        = (r_hold != 2'd0);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INST_ALPHA: n_cfg.inst_alpha = i_cfg_data[4:0];
                CFG_INST_COLOR: n_cfg.inst_color = i_cfg_data[14:0];
                CFG_INST_PID:   n_cfg.inst_pid   = i_cfg_data[5:0];
                CFG_OFFSET_X:   n_cfg.offset_x   = i_cfg_data;
                CFG_OFFSET_Y:   n_cfg.offset_y   = i_cfg_data;
                default:        n_cfg            = r_cfg;
            endcase
        end
        if (accept) begin
            n_hold = CORNER_LAST;
        end else if (r_hold != 2'd0) begin
            n_hold = r_hold - 2'd1;
        end else begin
            n_hold = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inst_alpha <= ALPHA_MAX;
            r_cfg.inst_color <= COLOR_WHITE;
            r_cfg.inst_pid   <= 6'd0;
            r_cfg.offset_x   <= 16'sd0;
            r_cfg.offset_y   <= 16'sd0;
            r_hold           <= 2'd0;
        end else begin
            r_cfg  <= n_cfg;
            r_hold <= n_hold;
        end
    end

    sqv_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_part  (i_part),
        .i_cfg   (r_cfg),
        .o_valid (s1_valid),
        .o_s1    (s1)
    );

    sqv_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_s1    (s1),
        .o_valid (s2_valid),
        .o_s2    (s2)
    );

    sqv_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s2_valid),
        .i_s2        (s2),
        .o_vtx_valid (o_vtx_valid),
        .o_vtx       (o_vtx)
    );

`ifndef SYNTHESIS
    a_busy_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy ##1 busy ##1 busy ##1 !busy)
        else $error("busy window after part transfer is wrong");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 (o_vtx_valid && o_vtx.corner == 2'd0))
        else $error("corner 0 not delivered on time");

    a_pipe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_valid |-> !s2_valid)
        else $error("two parts in adjacent stages");
`endif

endmodule
`default_nettype wire

// ===== test/sprite_quad_vertex_setup_tb.sv =====
// Testbench for sprite_quad_vertex_setup: directed and random sprite parts,
// checked corner by corner against a quad predictor kept inside this file.
// Depends on sqv_pkg and the sprite_quad_vertex_setup RTL.
module sprite_quad_vertex_setup_tb;
    import sqv_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_PARTS = 260;
    localparam int PRINT_CAP    = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_part       i_part = '0;
    logic        o_vtx_valid;
    t_vtx        o_vtx;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = CFG_INST_ALPHA;
    logic [15:0] i_cfg_data = '0;

    t_cfg settings_now;
    t_vtx pending_vertices[$];
    t_vtx seen_vtx;
    t_vtx want_vtx;
    int   mismatch_count = 0;
    int   cycle_count = 0;

    sprite_quad_vertex_setup i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_part      (i_part),
        .o_vtx_valid (o_vtx_valid),
        .o_vtx       (o_vtx),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_mismatch(string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Four corners of one part under the current instance settings.
    function automatic void predict_quad(t_part p);
        longint      tx, ty, bx, by, sx, sy, w, h;
        longint      m0, m1, m2, m3;
        longint      cx[4], cy[4];
        logic [14:0] ua, ub, va, vb, u0, u1, v0, v1, col;
        int          alpha;
        t_vtx        v;
        tx = longint'(signed'(p.pos_x));
        ty = longint'(signed'(p.pos_y));
        sx = p.src_rect[9:0];
        sy = p.src_rect[19:10];
        w  = p.src_rect[29:20];
        h  = p.src_rect[39:30];
        m0 = longint'(signed'(p.matrix[15:0]));
        m1 = longint'(signed'(p.matrix[31:16]));
        m2 = longint'(signed'(p.matrix[47:32]));
        m3 = longint'(signed'(p.matrix[63:48]));
        bx = tx + longint'(signed'(settings_now.offset_x)) * 4096;
        by = ty + longint'(signed'(settings_now.offset_y)) * 4096;
        cx[0] = bx;                 cy[0] = by;
        cx[1] = bx + m0 * w;        cy[1] = by + m2 * w;
        cx[2] = bx + m0 * w + m1 * h; cy[2] = by + m2 * w + m3 * h;
        cx[3] = bx + m1 * h;        cy[3] = by + m3 * h;
        ua = 15'(sx * 16);
        ub = 15'((sx + w) * 16);
        va = 15'(sy * 16);
        vb = 15'((sy + h) * 16);
        u0 = p.flip_flags[0] ? ub : ua;
        u1 = p.flip_flags[0] ? ua : ub;
        v0 = p.flip_flags[1] ? vb : va;
        v1 = p.flip_flags[1] ? va : vb;
        alpha = (int'(p.part_alpha) * (int'(settings_now.inst_alpha) + 1)) >> 5;
        if (alpha > int'(ALPHA_MAX)) begin
            alpha = int'(ALPHA_MAX);
        end
        if (settings_now.inst_color == COLOR_WHITE) begin
            col = p.part_color;
        end else if (p.part_color == COLOR_WHITE) begin
            col = settings_now.inst_color;
        end else begin
            for (int ch = 0; ch < 3; ch++) begin
                col[5*ch +: 5] = 5'((int'(p.part_color[5*ch +: 5])
                                  * int'(settings_now.inst_color[5*ch +: 5])) >> 5);
            end
        end
        for (int k = 0; k < 4; k++) begin
            v.corner       = 2'(k);
            v.vertex_x     = 16'(cx[k] >>> 12);
            v.vertex_y     = 16'(cy[k] >>> 12);
            v.vertex_z     = p.priority_req;
            v.tex_u        = (k == 1 || k == 2) ? u1 : u0;
            v.tex_v        = (k == 2 || k == 3) ? v1 : v0;
            v.vtx_alpha    = 5'(alpha);
            v.poly_id      = 6'(int'(settings_now.inst_pid) + int'(p.poly_id_offset)
                                + int'(p.part_index));
            v.vertex_color = col;
            v.last         = (v.corner == CORNER_LAST);
            pending_vertices.push_back(v);
        end
    endfunction

    function automatic t_part random_part();
        t_part       p;
        logic [15:0] entry_picks[5] = '{16'h7FFF, 16'h8000, 16'h1000, 16'hF000, 16'h0000};
        logic [31:0] pos_picks[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0};
        p.src_rect = 40'({$urandom, $urandom});
        if ($urandom_range(0, 7) == 0) begin
            p.src_rect[29:20] = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
        end
        if ($urandom_range(0, 7) == 0) begin
            p.src_rect[39:30] = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
        end
        for (int k = 0; k < 4; k++) begin
            p.matrix[16*k +: 16] = ($urandom_range(0, 3) == 0) ?
                                   entry_picks[$urandom_range(0, 4)] : 16'($urandom);
        end
        p.pos_x = ($urandom_range(0, 7) == 0) ? pos_picks[$urandom_range(0, 3)] : $urandom;
        p.pos_y = ($urandom_range(0, 7) == 0) ? pos_picks[$urandom_range(0, 3)] : $urandom;
        p.flip_flags     = 2'($urandom);
        p.priority_req   = 2'($urandom);
        p.part_alpha     = 5'($urandom);
        p.part_color     = ($urandom_range(0, 5) == 0) ? COLOR_WHITE : 15'($urandom);
        p.poly_id_offset = 6'($urandom);
        p.part_index     = 6'($urandom);
        return p;
    endfunction

    function automatic t_cfg random_settings();
        t_cfg c;
        c.inst_alpha = ($urandom_range(0, 3) == 0) ?
                       ($urandom_range(0, 1) ? ALPHA_MAX : 5'd0) : 5'($urandom);
        case ($urandom_range(0, 7))
            0, 1:    c.inst_color = COLOR_WHITE;
            2:       c.inst_color = 15'd0;
            default: c.inst_color = 15'($urandom);
        endcase
        c.inst_pid = 6'($urandom);
        c.offset_x = ($urandom_range(0, 3) == 0) ?
                     ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000) : 16'($urandom);
        c.offset_y = ($urandom_range(0, 3) == 0) ?
                     ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000) : 16'($urandom);
        return c;
    endfunction

    // Holds start until the part transfers; start is left high for a following part.
    task automatic send_part(t_part p);
        start  <= 1'b1;
        i_part <= p;
        do @(posedge i_clk); while (busy);
        predict_quad(p);
    endtask

    task automatic idle_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Block must be idle; writes all five registers back to back.
    task automatic load_settings(t_cfg c);
        t_cfg_idx idx;
        idx = CFG_INST_ALPHA;
        i_cfg_valid <= 1'b1;
        do begin
            i_cfg_index <= idx;
            case (idx)
                CFG_INST_ALPHA: i_cfg_data <= 16'(c.inst_alpha);
                CFG_INST_COLOR: i_cfg_data <= 16'(c.inst_color);
                CFG_INST_PID:   i_cfg_data <= 16'(c.inst_pid);
                CFG_OFFSET_X:   i_cfg_data <= c.offset_x;
                default:        i_cfg_data <= c.offset_y;
            endcase
            do @(posedge i_clk); while (!o_cfg_ready);
            idx = idx.next();
        end while (idx != CFG_INST_ALPHA);
        i_cfg_valid <= 1'b0;
        settings_now = c;
    endtask

    task automatic test_reset_values();
        t_part p;
        p = '0;
        send_part(p);
        p = '1;
        send_part(p);
        p.pos_x = 32'sh7FFF_FFFF;
        p.pos_y = 32'sh8000_0000;
        p.matrix = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
        p.part_color = 15'h0000;
        p.flip_flags = 2'd0;
        send_part(p);
        drain_results();
    endtask

    task automatic test_corner_geometry();
        t_part p;
        p = '0;
        p.src_rect = {10'd21, 10'd37, 10'd900, 10'd100};
        p.matrix = {16'h1000, 16'h0000, 16'h0000, 16'h1000};
        p.pos_x = 32'sd409600;
        p.pos_y = 32'sd204800;
        p.part_alpha = 5'd16;
        p.part_color = 15'h1234;
        for (int f = 0; f < 4; f++) begin
            p.flip_flags = 2'(f);
            p.priority_req = 2'(f);
            send_part(p);
        end
        // fractional negatives must round toward minus infinity
        p.pos_x = -32'sd1;
        p.pos_y = -32'sd4097;
        p.matrix = {16'hF000, 16'h0800, 16'hF800, 16'h0FFF};
        send_part(p);
        p.src_rect = {10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF};
        p.matrix = {4{16'h8000}};
        p.pos_x = 32'sh8000_0000;
        p.pos_y = 32'sh8000_0000;
        send_part(p);
        p.matrix = {4{16'h7FFF}};
        p.pos_x = 32'sh7FFF_FFFF;
        p.pos_y = 32'sh7FFF_FFFF;
        send_part(p);
        drain_results();
    endtask

    task automatic test_extreme_settings();
        t_cfg  c;
        t_part p;
        c.inst_alpha = 5'd0;
        c.inst_color = 15'd0;
        c.inst_pid   = 6'd63;
        c.offset_x   = 16'sh8000;
        c.offset_y   = 16'sh7FFF;
        load_settings(c);
        repeat (4) begin
            p = random_part();
            send_part(p);
        end
        p.part_color = COLOR_WHITE;
        p.part_alpha = 5'd31;
        send_part(p);
        drain_results();
        c.inst_alpha = ALPHA_MAX;
        c.inst_color = 15'h7FFE;
        c.inst_pid   = 6'd1;
        c.offset_x   = 16'sh7FFF;
        c.offset_y   = 16'sh8000;
        load_settings(c);
        repeat (4) begin
            p = random_part();
            send_part(p);
        end
        p.part_color = COLOR_WHITE;
        p.part_alpha = 5'd31;
        p.poly_id_offset = 6'd63;
        p.part_index = 6'd63;
        send_part(p);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int sent;
        int burst;
        sent = 0;
        while (sent < RANDOM_PARTS) begin
            if (sent % 52 == 0) begin
                drain_results();
                load_settings(random_settings());
            end
            burst = $urandom_range(1, 16);
            do begin
                send_part(random_part());
                sent++;
                burst--;
            end while (burst > 0 && sent < RANDOM_PARTS && sent % 52 != 0);
            case ($urandom_range(0, 9))
                0:       drain_results();
                1, 2:    ;
                default: idle_sender($urandom_range(1, 8));
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_vtx_valid) begin
            seen_vtx = o_vtx;
            if (pending_vertices.size() == 0) begin
                flag_mismatch($sformatf("vertex with nothing expected, corner %0d",
                                        seen_vtx.corner));
            end else begin
                want_vtx = pending_vertices.pop_front();
                if (seen_vtx.corner !== want_vtx.corner)
                    flag_mismatch($sformatf("corner %0d, want %0d",
                                            seen_vtx.corner, want_vtx.corner));
                if (seen_vtx.vertex_x !== want_vtx.vertex_x)
                    flag_mismatch($sformatf("vertex_x %h, want %h",
                                            seen_vtx.vertex_x, want_vtx.vertex_x));
                if (seen_vtx.vertex_y !== want_vtx.vertex_y)
                    flag_mismatch($sformatf("vertex_y %h, want %h",
                                            seen_vtx.vertex_y, want_vtx.vertex_y));
                if (seen_vtx.vertex_z !== want_vtx.vertex_z)
                    flag_mismatch($sformatf("vertex_z %0d, want %0d",
                                            seen_vtx.vertex_z, want_vtx.vertex_z));
                if (seen_vtx.tex_u !== want_vtx.tex_u)
                    flag_mismatch($sformatf("tex_u %h, want %h",
                                            seen_vtx.tex_u, want_vtx.tex_u));
                if (seen_vtx.tex_v !== want_vtx.tex_v)
                    flag_mismatch($sformatf("tex_v %h, want %h",
                                            seen_vtx.tex_v, want_vtx.tex_v));
                if (seen_vtx.vtx_alpha !== want_vtx.vtx_alpha)
                    flag_mismatch($sformatf("vtx_alpha %0d, want %0d",
                                            seen_vtx.vtx_alpha, want_vtx.vtx_alpha));
                if (seen_vtx.poly_id !== want_vtx.poly_id)
                    flag_mismatch($sformatf("poly_id %0d, want %0d",
                                            seen_vtx.poly_id, want_vtx.poly_id));
                if (seen_vtx.vertex_color !== want_vtx.vertex_color)
                    flag_mismatch($sformatf("vertex_color %h, want %h",
                                            seen_vtx.vertex_color, want_vtx.vertex_color));
                if (seen_vtx.last !== want_vtx.last)
                    flag_mismatch($sformatf("last %b, want %b",
                                            seen_vtx.last, want_vtx.last));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        settings_now.inst_alpha = ALPHA_MAX;
        settings_now.inst_color = COLOR_WHITE;
        settings_now.inst_pid   = 6'd0;
        settings_now.offset_x   = 16'sd0;
        settings_now.offset_y   = 16'sd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_corner_geometry();
        test_extreme_settings();
        test_random_traffic();
        drain_results();
        if (mismatch_count == 0 && pending_vertices.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
